FILE: rtl/core/rls_pkg.sv
package rls_pkg;

  typedef enum logic [1:0] {
    FUNC_SET_ONE = 2'd0,
    FUNC_SET_ALL = 2'd1,
    FUNC_SEND    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    SLOT_FIRST  = 2'd0,
    SLOT_SECOND = 2'd1,
    SLOT_BLUE   = 2'd2
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET,
    ST_READ,
    ST_LOAD,
    ST_OUT
  } state_t;

  // channel select handed to the scaler each write cycle
  typedef struct packed {
    slot_t slot;
    logic  swap;
  } chan_sel_t;

  localparam int unsigned WORD_W   = 12;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned BOUND_W  = 4;
  localparam int unsigned SLOTS    = 3;
  localparam logic [3:0]  BOUND_RST = 4'd4;

endpackage

FILE: rtl/core/rls_ram.sv
module rls_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/rls_scaler.sv
module rls_scaler import rls_pkg::*; (
  input  logic [COLOR_W-1:0] red,
  input  logic [COLOR_W-1:0] green,
  input  logic [COLOR_W-1:0] blue,
  input  chan_sel_t          sel,
  output logic [WORD_W-1:0]  word
);

  logic [COLOR_W-1:0] color;

  always_comb begin
    unique case (sel.slot)
      SLOT_FIRST:  color = sel.swap ? green : red;
      SLOT_SECOND: color = sel.swap ? red : green;
      SLOT_BLUE:   color = blue;
      default:     color = blue;
    endcase
  end

  // times 15 as x*16 - x, kept to the word width
  assign word = {color, 4'b0000} - {4'b0000, color};

endmodule

FILE: rtl/core/rgb_led_frame_serializer.sv
// rgb_led_frame_serializer: store of three 12-bit channel words per LED.
// input channel (in_valid/in_ready) takes one command transaction: func 0
// sets one LED, func 1 sets all LEDs, func 2 sends the frame. red, green and
// blue are scaled by 15; LEDs at or above the swap boundary store green
// before red. cfg_valid/cfg_ready writes the 4-bit swap boundary (reset 4);
// write it only while no command is in flight.
// output channel (out_valid/out_ready) carries one transaction per stored
// word on a send, in store order, with out_latch set on the last word.
// sequence: set one LED writes its 3 words, set all writes 3*NUM_LEDS words,
// one word is written per cycle through the shared scaler. a send reads each
// word from the registered store, loads it into one output register in ST_LOAD
// and offers the next word only after the current one is accepted in ST_OUT.
// in_ready is low the whole time.
// a stalled receiver just holds the current word; the walk resumes on accept.
// reset (rst_n, synchronous) marks every stored word as zero through per-word
// valid flags, sets the boundary to 4 and empties the output.
module rgb_led_frame_serializer import rls_pkg::*; #(
  parameter int unsigned NUM_LEDS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic [7:0]          in_led_index,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [11:0]         out_channel_word,
  output logic [5:0]          out_word_position,
  output logic                out_latch,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);

  localparam int unsigned WORDS = SLOTS * NUM_LEDS;
  localparam int unsigned AW    = $clog2(WORDS);
  localparam int unsigned LW    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);
  localparam logic [LW-1:0] LAST_LED  = LW'(NUM_LEDS - 1);

  state_t             state_r, state_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [LW-1:0]      led_r, led_nxt;
  slot_t              slot_r, slot_nxt;
  logic               all_r, all_nxt;
  logic [COLOR_W-1:0] red_r, green_r, blue_r;
  logic [BOUND_W-1:0] bound_r;
  logic [WORDS-1:0]   vld_r;
  logic               rd_vld_r;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_word_r;
  logic [AW-1:0]      out_pos_r;

  logic               in_acc;
  logic               out_acc;
  logic               wr_en;
  logic [AW-1:0]      rd_addr;
  logic [WORD_W-1:0]  scaled;
  logic [WORD_W-1:0]  rd_data;
  logic [9:0]         base_ext;
  chan_sel_t          sel;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;
  assign base_ext = {1'b0, in_led_index, 1'b0} + {2'b00, in_led_index};

  // next state
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    led_nxt       = led_r;
    slot_nxt      = slot_r;
    all_nxt       = all_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          slot_nxt = SLOT_FIRST;
          unique case (func_t'(in_func))
            FUNC_SET_ONE: begin
              if ({2'b00, in_led_index} < 10'(NUM_LEDS)) begin
                state_nxt = ST_SET;
                all_nxt   = 1'b0;
                led_nxt   = in_led_index[LW-1:0];
                addr_nxt  = base_ext[AW-1:0];
              end
            end
            FUNC_SET_ALL: begin
              state_nxt = ST_SET;
              all_nxt   = 1'b1;
              led_nxt   = '0;
              addr_nxt  = '0;
            end
            FUNC_SEND: begin
              state_nxt = ST_READ;
              addr_nxt  = '0;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SET: begin
        if (slot_r == SLOT_BLUE) begin
          if (all_r && (led_r != LAST_LED)) begin
            led_nxt  = led_r + 1'b1;
            slot_nxt = SLOT_FIRST;
            addr_nxt = addr_r + 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          slot_nxt = slot_t'(slot_r + 2'd1);
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: begin
        state_nxt     = ST_OUT;
        out_valid_nxt = 1'b1;
      end
      ST_OUT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (addr_r == LAST_ADDR) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_LOAD;
            addr_nxt  = addr_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    wr_en     = (state_r == ST_SET);
    sel.slot  = slot_r;
    sel.swap  = !({{(8-LW){1'b0}}, led_r} < {4'b0000, bound_r});
    // on a word handoff the next read goes out in the same cycle
    if ((state_r == ST_OUT) && out_acc && (addr_r != LAST_ADDR)) begin
      rd_addr = addr_r + 1'b1;
    end else begin
      rd_addr = addr_r;
    end
  end

  rls_scaler u_scaler (
    .red   (red_r),
    .green (green_r),
    .blue  (blue_r),
    .sel   (sel),
    .word  (scaled)
  );

  rls_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr_r),
    .wdata (scaled),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bound_r     <= BOUND_RST;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        bound_r <= cfg_data;
      end
      if (wr_en) begin
        vld_r[addr_r] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    led_r  <= led_nxt;
    slot_r <= slot_nxt;
    all_r  <= all_nxt;
    if (in_acc) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
    if (state_r == ST_LOAD) begin
      out_word_r <= rd_vld_r ? rd_data : '0;
      out_pos_r  <= addr_r;
    end
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_channel_word  = out_word_r;
  assign out_word_position = POS_W'(out_pos_r);
  assign out_latch         = (out_pos_r == LAST_ADDR);

`ifndef SYNTHESIS
  a_out_only_in_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_OUT))
    else $error("result shown outside the send walk");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("command taken while busy");

  a_last_word_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_latch) |=> (state_r == ST_IDLE))
    else $error("send did not finish after the latch word");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (addr_r <= LAST_ADDR))
    else $error("store write beyond the chain");
`endif

endmodule

FILE: tb/rgb_led_frame_serializer_tb.sv
module rgb_led_frame_serializer_tb;
  import rls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_LEDS     = 8;
  localparam int unsigned NUM_WORDS    = SLOTS * NUM_LEDS;
  localparam int unsigned SCALE        = 15;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned HOLD_LEN     = 300;
  localparam int unsigned DRAIN_LIMIT  = 20000;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned PHASE_ITEMS  = 25;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    func_t             func;
    logic [COLOR_W-1:0] led_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } led_cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [POS_W-1:0]  pos;
    logic              latch;
  } frame_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_func = '0;
  logic [7:0]          in_led_index = '0;
  logic [7:0]          in_red = '0;
  logic [7:0]          in_green = '0;
  logic [7:0]          in_blue = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [11:0]         out_channel_word;
  logic [5:0]          out_word_position;
  logic                out_latch;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [3:0]          cfg_data = '0;

  // predicted block state
  logic [WORD_W-1:0]   led_words [NUM_WORDS] = '{default: '0};
  logic [BOUND_W-1:0]  swap_bound = BOUND_RST;

  led_cmd_t            cmd_queue [$];
  frame_word_t         frame_words_q [$];
  led_cmd_t            cur_cmd = '0;

  int                  tx_gap = 0;
  int                  rx_gap = 0;
  bit                  sender_burst = 1'b0;
  bit                  receiver_burst = 1'b0;

  logic                hold_req = 1'b0;
  logic                holding = 1'b0;
  logic                hold_done = 1'b0;
  int unsigned         hold_cnt = 0;

  int unsigned         errors = 0;
  int unsigned         cycle_count = 0;
  int unsigned         n_set_one = 0;
  int unsigned         n_set_all = 0;
  int unsigned         n_sends = 0;
  int unsigned         n_ignored = 0;
  int unsigned         n_words = 0;
  int unsigned         n_bounds = 0;

  rgb_led_frame_serializer #(
    .NUM_LEDS(NUM_LEDS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_led_index     (in_led_index),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_channel_word (out_channel_word),
    .out_word_position(out_word_position),
    .out_latch        (out_latch),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void store_led(int led, led_cmd_t c);
    int base;
    base = led * SLOTS;
    if (led < swap_bound) begin
      led_words[base]     = 12'(c.red * SCALE);
      led_words[base + 1] = 12'(c.green * SCALE);
    end else begin
      led_words[base]     = 12'(c.green * SCALE);
      led_words[base + 1] = 12'(c.red * SCALE);
    end
    led_words[base + 2] = 12'(c.blue * SCALE);
  endfunction

  // updates the predicted store and queues the words a send will emit
  function automatic void apply_command(led_cmd_t c);
    frame_word_t w;
    case (c.func)
      FUNC_SET_ONE: begin
        if (c.led_index < NUM_LEDS) begin
          store_led(c.led_index, c);
          n_set_one++;
        end else begin
          n_ignored++;
        end
      end
      FUNC_SET_ALL: begin
        for (int i = 0; i < NUM_LEDS; i++) store_led(i, c);
        n_set_all++;
      end
      FUNC_SEND: begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          w.word  = led_words[i];
          w.pos   = 6'(i);
          w.latch = (i == NUM_WORDS - 1);
          frame_words_q.push_back(w);
        end
        n_sends++;
      end
      default: n_ignored++;
    endcase
  endfunction

  function automatic void push_cmd(func_t f, int idx, int r, int g, int b);
    led_cmd_t c;
    c.func      = f;
    c.led_index = 8'(idx);
    c.red       = 8'(r);
    c.green     = 8'(g);
    c.blue      = 8'(b);
    cmd_queue.push_back(c);
  endfunction

  function automatic led_cmd_t random_command();
    led_cmd_t c;
    int sel;
    sel = $urandom_range(0, 99);
    c.led_index = 8'($urandom_range(0, NUM_LEDS - 1));
    c.red       = 8'($urandom);
    c.green     = 8'($urandom);
    c.blue      = 8'($urandom);
    if (sel < 48) begin
      c.func = FUNC_SET_ONE;
    end else if (sel < 56) begin
      c.func      = FUNC_SET_ONE;
      c.led_index = 8'($urandom_range(NUM_LEDS, 255));
    end else if (sel < 68) begin
      c.func = FUNC_SET_ALL;
    end else if (sel < 90) begin
      c.func = FUNC_SEND;
    end else begin
      c.func      = FUNC_NONE;
      c.led_index = 8'($urandom);
    end
    return c;
  endfunction

  // input driver
  always @(posedge clk) begin : driver
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        apply_command(cur_cmd);
        offer  = 1'b0;
        tx_gap = sender_burst ? 0 : $urandom_range(0, 11);
      end
      if (!offer) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (cmd_queue.size() != 0) begin
          cur_cmd = cmd_queue.pop_front();
          offer   = 1'b1;
        end
      end
      in_valid     <= offer;
      in_func      <= cur_cmd.func;
      in_led_index <= cur_cmd.led_index;
      in_red       <= cur_cmd.red;
      in_green     <= cur_cmd.green;
      in_blue      <= cur_cmd.blue;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : monitor
    frame_word_t exp_w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_words++;
        if (frame_words_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected word: got word %h pos %0d latch %b",
                     out_channel_word, out_word_position, out_latch);
        end else begin
          exp_w = frame_words_q.pop_front();
          if ({out_channel_word, out_word_position, out_latch} !== exp_w) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("word mismatch: expected word %h pos %0d latch %b, got %h pos %0d latch %b",
                       exp_w.word, exp_w.pos, exp_w.latch,
                       out_channel_word, out_word_position, out_latch);
          end
        end
        rx_gap = receiver_burst ? 0 : $urandom_range(0, 11);
      end else if (rx_gap > 0) begin
        rx_gap--;
      end
      out_ready <= (rx_gap == 0) && !holding;
    end
  end

  // one long receiver hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      holding   <= 1'b0;
      hold_done <= 1'b0;
      hold_cnt  <= 0;
    end else if (holding) begin
      if (hold_cnt == HOLD_LEN - 1) begin
        holding   <= 1'b0;
        hold_done <= 1'b1;
      end
      hold_cnt <= hold_cnt + 1;
    end else if (hold_req && !hold_done) begin
      holding  <= 1'b1;
      hold_cnt <= 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending",
               cycle_count, frame_words_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // every pending command accepted and every predicted word seen
  task automatic wait_drained();
    while (cmd_queue.size() != 0 || in_valid || frame_words_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_boundary(logic [BOUND_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    swap_bound = value;
    n_bounds++;
  endtask

  initial begin : stimulus
    logic [BOUND_W-1:0] bounds [6];
    int k;

    bounds = '{4'd0, 4'd8, 4'd15, 4'd9, 4'd0, 4'd4};
    bounds[4] = 4'($urandom_range(0, 15));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at the reset boundary
    push_cmd(FUNC_SEND, 0, 0, 0, 0);
    push_cmd(FUNC_SET_ONE, 0, 255, 0, 128);
    push_cmd(FUNC_SET_ONE, 3, 8'hAA, 8'h55, 8'hFF);
    push_cmd(FUNC_SET_ONE, 4, 8'h55, 8'hAA, 8'h00);
    push_cmd(FUNC_SET_ONE, 7, 255, 255, 255);
    push_cmd(FUNC_SET_ONE, NUM_LEDS, 1, 2, 3);
    push_cmd(FUNC_SET_ONE, 255, 9, 9, 9);
    push_cmd(FUNC_SET_ONE, 8'h80, 7, 7, 7);
    push_cmd(FUNC_NONE, 1, 200, 100, 50);
    push_cmd(FUNC_SEND, 0, 0, 0, 0);
    push_cmd(FUNC_SET_ALL, 0, 255, 0, 0);
    push_cmd(FUNC_SEND, 0, 0, 0, 0);
    push_cmd(FUNC_SET_ALL, 0, 8'h12, 8'h34, 8'h56);
    push_cmd(FUNC_SET_ONE, 5, 0, 255, 1);
    push_cmd(FUNC_SET_ONE, 2, 8'hF0, 8'h0F, 8'hC3);
    push_cmd(FUNC_SEND, 255, 255, 255, 255);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_boundary(bounds[p]);
      @(negedge clk);
      if (p == 1) begin
        // no idling on either side
        sender_burst   = 1'b1;
        receiver_burst = 1'b1;
      end
      if (p == 3) begin
        // sends mixed with random commands, no sender gaps, while the receiver holds off
        sender_burst = 1'b1;
        for (int s = 0; s < 4; s++) begin
          push_cmd(FUNC_SEND, 0, 0, 0, 0);
          cmd_queue.push_back(random_command());
        end
        for (int i = 0; i < PHASE_ITEMS - 8; i++) cmd_queue.push_back(random_command());
        @(posedge clk);
        hold_req <= 1'b1;
        while (!hold_done) @(negedge clk);
        sender_burst = 1'b0;
        hold_req <= 1'b0;
      end else begin
        for (int i = 0; i < PHASE_ITEMS; i++) cmd_queue.push_back(random_command());
      end
      if (p == 1) begin
        wait_drained();
        @(negedge clk);
        sender_burst   = 1'b0;
        receiver_burst = 1'b0;
      end
    end

    while (cmd_queue.size() != 0 || in_valid) @(negedge clk);
    for (k = 0; k < DRAIN_LIMIT && frame_words_q.size() != 0; k++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (frame_words_q.size() != 0) begin
      $display("%0d predicted words never arrived", frame_words_q.size());
      errors += frame_words_q.size();
    end

    $display("ran %0d set-one, %0d set-all, %0d frame sends, %0d ignored commands",
             n_set_one, n_set_all, n_sends, n_ignored);
    $display("checked %0d channel words over %0d swap boundary writes, %0d errors",
             n_words, n_bounds, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
